### src/mm64_pkg.sv
// Shared constants, command struct and helper functions for the MurmurHash64A block.
`default_nettype none

package mm64_pkg;

  localparam int unsigned HASH_W    = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned MSG_LEN_W = 32;
  localparam int unsigned COUNT_W   = 4;

  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam logic [HASH_W-1:0] MIX_MUL    = 64'd14313749767032793493;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'd3782874213;
  localparam int unsigned       MIX_SHIFT  = 47;

  // Multiplier phase codes; the last one is the cycle where the product is used
  localparam logic [1:0] PH_LO     = 2'd0;  // a_lo * m_lo, full 64-bit product
  localparam logic [1:0] PH_AHI    = 2'd1;  // a_hi * m_lo, low half into upper word
  localparam logic [1:0] PH_MHI    = 2'd2;  // a_lo * m_hi, low half into upper word
  localparam logic [1:0] PH_COMMIT = 2'd3;

  // Running-hash update select
  localparam logic [1:0] H_KEEP = 2'd0;
  localparam logic [1:0] H_INIT = 2'd1;  // seed ^ product
  localparam logic [1:0] H_FOLD = 2'd2;  // hash ^ product
  localparam logic [1:0] H_PROD = 2'd3;  // product

  // Multiplier operand select
  localparam logic [2:0] M_KEEP = 3'd0;
  localparam logic [2:0] M_LEN  = 3'd1;  // masked length
  localparam logic [2:0] M_WORD = 3'd2;  // masked word (key)
  localparam logic [2:0] M_HW   = 3'd3;  // next hash ^ masked word (tail)
  localparam logic [2:0] M_HF   = 3'd4;  // xorshift of next hash (finalize)
  localparam logic [2:0] M_PF   = 3'd5;  // xorshift of product (key mix)
  localparam logic [2:0] M_HX   = 3'd6;  // next hash (hash multiply)

  typedef struct packed {
    logic       ld;      // capture the accepted input beat
    logic       mul_en;  // run one multiplier phase
    logic [1:0] mul_ph;
    logic [1:0] h_sel;
    logic [2:0] m_sel;
    logic       out_ld;  // load finalized hash into the output register
  } mm64_cmd_t;

  function automatic logic [HASH_W-1:0] xorshift(input logic [HASH_W-1:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  // Keep the low bytes given by the count; eight or more keeps the whole word
  function automatic logic [HASH_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
    logic [HASH_W-1:0] m;
    m = '0;
    for (int b = 0; b < HASH_W / 8; b++) begin
      if ((cnt[COUNT_W-1]) || (b < int'(cnt))) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### src/mm64_dpath.sv
// Datapath: seed, running hash, shared 32x32 multiplier and output register.
`default_nettype none

module mm64_dpath
  import mm64_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mm64_cmd_t            cmd,
  input  wire logic                 cfg_wr_en,
  input  wire logic [HASH_W-1:0]    cfg_wr_data,
  input  wire logic [HASH_W-1:0]    in_data_word,
  input  wire logic [COUNT_W-1:0]   in_byte_count,
  input  wire logic [MSG_LEN_W-1:0] in_msg_length,
  output logic      [HASH_W-1:0]    out_hash_value
);

  logic [HASH_W-1:0]    seed_r;
  logic [HASH_W-1:0]    h_r, h_nxt;
  logic [HASH_W-1:0]    w_r;
  logic [HASH_W-1:0]    m_r, m_nxt;
  logic [HASH_W-1:0]    prod_r;
  logic [HASH_W-1:0]    out_r;
  logic [HASH_W-1:0]    word_src;
  logic [MSG_LEN_W-1:0] len_m;
  logic [HALF_W-1:0]    mul_a, mul_b;
  logic [HASH_W-1:0]    mul_p;

  // Length limited to LENGTH_BITS
  always_comb begin
    for (int i = 0; i < MSG_LEN_W; i++) begin
      len_m[i] = in_msg_length[i] & (i < LENGTH_BITS);
    end
  end

  // Word: the incoming beat on load, the stored one afterwards
  assign word_src = cmd.ld ? (in_data_word & byte_mask(in_byte_count)) : w_r;

  // Running hash next value
  always_comb begin
    unique case (cmd.h_sel)
      H_KEEP:  h_nxt = h_r;
      H_INIT:  h_nxt = seed_r ^ prod_r;
      H_FOLD:  h_nxt = h_r ^ prod_r;
      H_PROD:  h_nxt = prod_r;
      default: h_nxt = h_r;
    endcase
  end

  // Multiplier operand next value
  always_comb begin
    unique case (cmd.m_sel)
      M_KEEP:  m_nxt = m_r;
      M_LEN:   m_nxt = {{(HASH_W-MSG_LEN_W){1'b0}}, len_m};
      M_WORD:  m_nxt = word_src;
      M_HW:    m_nxt = h_nxt ^ word_src;
      M_HF:    m_nxt = xorshift(h_nxt);
      M_PF:    m_nxt = xorshift(prod_r);
      M_HX:    m_nxt = h_nxt;
      default: m_nxt = m_r;
    endcase
  end

  // One 32x32 multiplier; the low 64 bits of m_r * MIX_MUL over three phases
  assign mul_a = (cmd.mul_ph == PH_AHI) ? m_r[HASH_W-1:HALF_W] : m_r[HALF_W-1:0];
  assign mul_b = (cmd.mul_ph == PH_MHI) ? MIX_MUL[HASH_W-1:HALF_W] : MIX_MUL[HALF_W-1:0];
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_ph == PH_LO) begin
        prod_r <= mul_p;
      end else begin
        prod_r[HASH_W-1:HALF_W] <= prod_r[HASH_W-1:HALF_W] + mul_p[HALF_W-1:0];
      end
    end
  end

  // Operand, stored word and result registers
  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    if (cmd.ld) begin
      w_r <= word_src;
    end
    if (cmd.out_ld) begin
      out_r <= xorshift(prod_r);
    end
  end

  // Seed and running hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
      h_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      h_r <= h_nxt;
    end
  end

  assign out_hash_value = out_r;

endmodule

`default_nettype wire

### src/mm64_ctrl.sv
// Controller: sequences loads, multiplier phases and hash updates per beat.
`default_nettype none

module mm64_ctrl
  import mm64_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COUNT_W-1:0] in_byte_count,
  input  wire logic               in_first_word,
  input  wire logic               in_last_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mm64_cmd_t               cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;  // length * M
  localparam logic [2:0] S_KEY1 = 3'd2;  // first key multiply
  localparam logic [2:0] S_KEY2 = 3'd3;  // second key multiply
  localparam logic [2:0] S_HASH = 3'd4;  // hash * M
  localparam logic [2:0] S_FIN  = 3'd5;  // finalize multiply

  logic [2:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       full_r, tail_r, last_r;
  logic       out_valid_r, out_valid_nxt;
  logic       idle, accept, commit, out_free;
  logic       full_c, tail_c, last_c;
  logic [2:0] route_m;
  logic [2:0] route_s;

  assign idle     = (state_r == S_IDLE);
  assign in_stall = !idle;
  assign accept   = in_valid && idle;
  assign commit   = (ph_r == PH_COMMIT);
  assign out_free = !out_valid_r || !out_stall;

  // Word class: live inputs while idle, captured flags otherwise
  assign full_c = idle ? in_byte_count[COUNT_W-1] : full_r;
  assign tail_c = idle ? ((in_byte_count != '0) && !in_byte_count[COUNT_W-1]) : tail_r;
  assign last_c = idle ? in_last_word : last_r;

  // Where a word goes once the running hash is ready
  always_comb begin
    priority if (full_c) begin
      route_m = M_WORD;
      route_s = S_KEY1;
    end else if (tail_c) begin
      route_m = M_HW;
      route_s = S_HASH;
    end else if (last_c) begin
      route_m = M_HF;
      route_s = S_FIN;
    end else begin
      route_m = M_KEEP;
      route_s = S_IDLE;
    end
  end

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ph_nxt    = ph_r;
    if (!idle && !commit) begin
      cmd.mul_en = 1'b1;
      cmd.mul_ph = ph_r;
      ph_nxt     = ph_r + 2'd1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.ld = 1'b1;
          ph_nxt = PH_LO;
          if (in_first_word) begin
            cmd.m_sel = M_LEN;
            state_nxt = S_INIT;
          end else begin
            cmd.m_sel = route_m;
            state_nxt = route_s;
          end
        end
      end
      S_INIT: begin
        if (commit) begin
          cmd.h_sel = H_INIT;
          cmd.m_sel = route_m;
          state_nxt = route_s;
          ph_nxt    = PH_LO;
        end
      end
      S_KEY1: begin
        if (commit) begin
          cmd.m_sel = M_PF;
          state_nxt = S_KEY2;
          ph_nxt    = PH_LO;
        end
      end
      S_KEY2: begin
        if (commit) begin
          cmd.h_sel = H_FOLD;
          cmd.m_sel = M_HX;
          state_nxt = S_HASH;
          ph_nxt    = PH_LO;
        end
      end
      S_HASH: begin
        if (commit) begin
          cmd.h_sel = H_PROD;
          cmd.m_sel = M_HF;
          state_nxt = last_r ? S_FIN : S_IDLE;
          ph_nxt    = PH_LO;
        end
      end
      S_FIN: begin
        // hold the product until the output register is free
        if (commit && out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
          ph_nxt     = PH_LO;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ph_nxt    = PH_LO;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_ld || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_LO;
      full_r      <= 1'b0;
      tail_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        full_r <= full_c;
        tail_r <= tail_c;
        last_r <= last_c;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### src/murmur64a_stream_hash.sv
// Top level: streaming MurmurHash64A, controller plus datapath.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | data_word, byte_count, first/last, msg_length
//  out     | output    | out_valid/out_stall| hash_value
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (hash seed)
//
// Every 64-bit multiply runs on one shared 32x32 multiplier: three phases plus
// a commit step that uses the product. Per beat: accept, then length (first),
// two key and one hash multiply (full), hash (tail), finalize (last).
// Synchronous active-low reset; the seed resets to 3782874213.
// The next beat is taken while a finished hash waits in the output register;
// a second hash waits in the finalize step until the output beat is taken.
`default_nettype none

module murmur64a_stream_hash
  import mm64_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [HASH_W-1:0]    cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [HASH_W-1:0]    in_data_word,
  input  wire logic [COUNT_W-1:0]   in_byte_count,
  input  wire logic                 in_first_word,
  input  wire logic                 in_last_word,
  input  wire logic [MSG_LEN_W-1:0] in_msg_length,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [HASH_W-1:0]    out_hash_value
);

  mm64_cmd_t cmd;

  mm64_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_count (in_byte_count),
    .in_first_word (in_first_word),
    .in_last_word  (in_last_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  mm64_dpath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_msg_length  (in_msg_length),
    .out_hash_value (out_hash_value)
  );

`ifndef NO_ASSERTIONS
  // A new hash never overwrites one still waiting on the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid || !out_stall))
    else $error("output register loaded while a hash was pending");

  // A beat that carries work keeps the input stalled in the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_first_word || in_last_word || in_byte_count != '0))
    |=> in_stall)
    else $error("input accepted again before the previous beat finished");

  // The multiplier only runs while a beat is in progress
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> in_stall)
    else $error("multiplier active while idle");
`endif

endmodule

`default_nettype wire

### tb/tb_murmur64a_stream_hash.sv
// Self-checking testbench for the streaming MurmurHash64A block.
`default_nettype none

module tb_murmur64a_stream_hash;
  import mm64_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;    // longer than the longest beat
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles without any input or output handshake
  localparam int unsigned SEG_BEATS     = 134;   // random beats per seed setting
  localparam int unsigned MAX_REPORTS   = 10;

  // One input beat as the block sees it
  typedef struct packed {
    logic [HASH_W-1:0]    data;
    logic [COUNT_W-1:0]   count;
    logic                 first;
    logic                 last;
    logic [MSG_LEN_W-1:0] length;
  } word_beat_t;

  // Directed row; a typed hash replaces the computed one where it is obvious
  typedef struct {
    word_beat_t        beat;
    bit                typed;
    logic [HASH_W-1:0] typed_hash;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_wr_en      = 1'b0;
  logic [HASH_W-1:0]    cfg_wr_data    = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [HASH_W-1:0]    in_data_word   = '0;
  logic [COUNT_W-1:0]   in_byte_count  = '0;
  logic                 in_first_word  = 1'b0;
  logic                 in_last_word   = 1'b0;
  logic [MSG_LEN_W-1:0] in_msg_length  = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [HASH_W-1:0]    out_hash_value;

  // Local copy of the block state
  logic [HASH_W-1:0] seed_q   = SEED_RESET;
  logic [HASH_W-1:0] run_hash = '0;

  logic [HASH_W-1:0] hash_due [$];
  dir_row_t          dir_rows [$];
  int unsigned       beats_sent    = 0;
  int unsigned       faults        = 0;
  int unsigned       idle_cycles   = 0;
  int unsigned       in_idle_pct   = 6;
  int unsigned       out_stall_pct = 66;

  murmur64a_stream_hash dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_first_word  (in_first_word),
    .in_last_word   (in_last_word),
    .in_msg_length  (in_msg_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Key mix: multiply, xorshift, multiply, all mod 2^64
  function automatic logic [HASH_W-1:0] mix_key64(input logic [HASH_W-1:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL;
    return k;
  endfunction

  // Advance the running hash by one beat; finalize on a last beat
  task automatic fold_beat(input word_beat_t b, output bit emits,
                           output logic [HASH_W-1:0] digest);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] keep;
    if (b.first) begin
      run_hash = seed_q ^ ({{(HASH_W-MSG_LEN_W){1'b0}}, b.length} * MIX_MUL);
    end
    h = run_hash;
    if (b.count >= 8) begin
      h = (h ^ mix_key64(b.data)) * MIX_MUL;
    end else if (b.count != 0) begin
      keep = (64'd1 << (b.count * 8)) - 64'd1;
      h = (h ^ (b.data & keep)) * MIX_MUL;
    end
    run_hash = h;
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_MUL;
    h = h ^ (h >> MIX_SHIFT);
    emits  = b.last;
    digest = h;
  endtask

  function automatic void dir_row(input logic [HASH_W-1:0] data, input int unsigned count,
                                  input bit first, input bit last,
                                  input logic [MSG_LEN_W-1:0] length,
                                  input bit typed, input logic [HASH_W-1:0] typed_hash);
    dir_row_t r;
    r.beat.data   = data;
    r.beat.count  = COUNT_W'(count);
    r.beat.first  = first;
    r.beat.last   = last;
    r.beat.length = length;
    r.typed       = typed;
    r.typed_hash  = typed_hash;
    dir_rows.push_back(r);
  endfunction

  // Present one beat, hold it through stalls, then record the expected hash of a last beat
  task automatic send_beat(input word_beat_t b, input bit typed,
                           input logic [HASH_W-1:0] typed_hash);
    bit                emits;
    logic [HASH_W-1:0] digest;
    if ($urandom_range(99, 0) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < in_idle_pct);
    end
    in_valid      <= 1'b1;
    in_data_word  <= b.data;
    in_byte_count <= b.count;
    in_first_word <= b.first;
    in_last_word  <= b.last;
    in_msg_length <= b.length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_beat(b, emits, digest);
    if (emits) begin
      hash_due.push_back(typed ? typed_hash : digest);
    end
    beats_sent++;
  endtask

  // Message split into words; length field and last mark may be broken
  task automatic send_message(input int unsigned len, input logic [MSG_LEN_W-1:0] len_field,
                              input bit drop_last);
    int unsigned words;
    word_beat_t  b;
    words = (len == 0) ? 1 : (len + 7) / 8;
    for (int unsigned w = 0; w < words; w++) begin
      b.data   = {$urandom, $urandom};
      if (len == 0) begin
        b.count = '0;
      end else if (w == words - 1 && len % 8 != 0) begin
        b.count = COUNT_W'(len % 8);
      end else begin
        b.count = COUNT_W'(8);
      end
      b.first  = (w == 0);
      b.last   = (w == words - 1) && !drop_last;
      b.length = (w == 0) ? len_field : MSG_LEN_W'($urandom);
      send_beat(b, 1'b0, '0);
    end
  endtask

  // Let the block go quiet: all hashes back, then its longest beat
  task automatic settle_block();
    in_valid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void log_fault(input string what, input logic [HASH_W-1:0] want,
                                    input logic [HASH_W-1:0] got);
    if (faults < MAX_REPORTS) begin
      $display("ERROR %s: expected %h, got %h", what, want, got);
    end
    faults++;
  endfunction

  // Result side: check each taken beat, then pick the next stall
  always @(posedge clk) begin : hash_check
    logic [HASH_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hash_due.size() == 0) begin
          log_fault("unexpected hash", '0, out_hash_value);
        end else begin
          want = hash_due.pop_front();
          if (want != out_hash_value) begin
            log_fault("hash_value mismatch", want, out_hash_value);
          end
        end
      end
      out_stall <= ($urandom_range(99, 0) < out_stall_pct);
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    word_beat_t        b;
    int unsigned       pick;
    int unsigned       len;
    logic [HASH_W-1:0] seed_v;

    // Directed rows: reset state, extremes and odd byte counts
    dir_row(64'h0, 0, 0, 1, 32'd0, 1, 64'h0);       // last with no first, straight after reset
    dir_row(64'hDEAD_BEEF_0BAD_F00D, 0, 0, 0, 32'd0, 0, '0);  // zero bytes, not last
    dir_row(64'h0, 5, 0, 1, 32'd5, 1, 64'h0);       // zero tail into zero hash
    dir_row(64'h0, 0, 1, 1, 32'd0, 0, '0);          // empty message
    dir_row(64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 1, 32'hFFFF_FFFF, 0, '0);
    dir_row(64'hFFFF_FFFF_FFFF_FFFF, 8, 1, 1, 32'd8, 0, '0);
    dir_row(64'h0, 8, 1, 0, 32'd16, 0, '0);
    dir_row(64'hFFFF_FFFF_FFFF_FFFF, 8, 0, 1, 32'd0, 0, '0);
    dir_row(64'h0123_4567_89AB_CDEF, 8, 1, 0, 32'd13, 0, '0);
    dir_row(64'hFFFF_FFFF_FFFF_FFFF, 5, 0, 1, 32'd0, 0, '0);  // bytes past the count
    dir_row(64'h0123_4567_89AB_CDEF, 15, 1, 1, 32'd8, 0, '0); // count above eight
    dir_row(64'hFEDC_BA98_7654_3210, 9, 1, 1, 32'd8, 0, '0);
    dir_row(64'h00AA_BBCC_DDEE_FF11, 3, 1, 0, 32'd11, 0, '0); // tail that is not last
    dir_row(64'h5555_5555_5555_5555, 8, 0, 0, 32'd0, 0, '0);
    dir_row(64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 1, 32'd0, 0, '0);
    dir_row(64'h8000_0000_0000_0001, 8, 1, 0, 32'd15, 0, '0);
    dir_row(64'h7FFF_FFFF_FFFF_FFFE, 0, 0, 0, 32'd0, 0, '0);  // zero bytes mid message
    dir_row(64'h1122_3344_5566_7788, 7, 0, 1, 32'd0, 0, '0);
    dir_row(64'hA5A5_5A5A_A5A5_5A5A, 8, 0, 1, 32'd0, 0, '0);  // no first after a finished one
    dir_row(64'h0000_0000_0000_00FF, 1, 1, 1, 32'd1, 0, '0);
    dir_row(64'hA5A5_A5A5_A5A5_A5A5, 4, 1, 1, 32'd4, 0, '0);
    dir_row(64'h8000_0000_0000_0000, 8, 1, 1, 32'hFFFF_FFFF, 0, '0);
    dir_row(64'h0F0F_0F0F_0F0F_0F0F, 8, 1, 0, 32'd10, 0, '0);
    dir_row(64'hF0F0_F0F0_F0F0_F0F0, 2, 1, 1, 32'd2, 0, '0);  // first again restarts

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].typed_hash);
    end

    // Random traffic, two seed settings per idling mode
    for (int seg = 0; seg < 6; seg++) begin
      settle_block();
      case (seg / 2)
        0: begin in_idle_pct = 6;  out_stall_pct = 66; end
        1: begin in_idle_pct = 66; out_stall_pct = 6;  end
        default: begin in_idle_pct = 0; out_stall_pct = 0; end
      endcase
      case (seg)
        0: seed_v = '0;
        1: seed_v = '1;
        3: seed_v = SEED_RESET;
        default: seed_v = {$urandom, $urandom};
      endcase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= seed_v;
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      seed_q      = seed_v;

      while (beats_sent < dir_rows.size() + (seg + 1) * SEG_BEATS) begin
        pick = $urandom_range(99, 0);
        len  = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 0) : $urandom_range(24, 0);
        if (pick < 75) begin
          send_message(len, MSG_LEN_W'(len), 1'b0);
        end else if (pick < 88) begin
          send_message(len, MSG_LEN_W'($urandom), $urandom_range(2, 0) == 0);
        end else begin
          b.data   = {$urandom, $urandom};
          b.count  = COUNT_W'($urandom_range(15, 0));
          b.first  = 1'($urandom_range(1, 0));
          b.last   = 1'($urandom_range(1, 0));
          b.length = MSG_LEN_W'($urandom);
          send_beat(b, 1'b0, '0);
        end
      end
    end

    settle_block();
    if (faults == 0 && hash_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### murmur64a_stream_hash.f
src/mm64_pkg.sv
src/mm64_dpath.sv
src/mm64_ctrl.sv
src/murmur64a_stream_hash.sv
tb/tb_murmur64a_stream_hash.sv
